FILE: design/kmc_pkg.sv
// Shared types, constants and codes of the 2-D k-means clustering block.
package kmc_pkg;

    localparam int COORD_BITS       = 16;
    localparam int MAX_POINTS_DEF   = 64;
    localparam int MAX_CLUSTERS_DEF = 8;
    localparam int DIST_W           = 2 * COORD_BITS + 2;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 8;
    localparam int LIMIT_W          = 8;
    localparam int CCOUNT_W         = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 8'd1;

    localparam logic [CCOUNT_W-1:0] CLUSTER_COUNT_RST = 4'd2;
    localparam logic [LIMIT_W-1:0]  ITER_LIMIT_RST    = 8'd100;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         final_point;
    } point_t;

    typedef struct packed {
        logic [2:0]                   cluster_index;
        logic [5:0]                   point_index;
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic                         last_result;
    } result_t;

    typedef struct packed {
        logic pt_wr;
        logic mean0;
        logic dist_en;
        logic cmp;
        logic cmp_first;
        logic far_upd;
        logic far_first;
        logic mean_far;
        logic sum_clr;
        logic sum_acc;
        logic lbl_wr;
        logic div_start;
        logic mean_upd;
        logic emit;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic changed;
        logic lbl_match;
        logic out_free;
    } status_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT0,
        ST_INIT1,
        ST_FETCH,
        ST_DIST,
        ST_CMP,
        ST_POST,
        ST_FP_SET,
        ST_IT_START,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT_FETCH,
        ST_OUT_CHK
    } state_t;

    typedef enum logic [1:0] {
        PH_FP,
        PH_LLOYD,
        PH_LABEL
    } phase_t;

endpackage

FILE: design/kmc_div.sv
// Radix-2 restoring divider for signed sum by unsigned count, truncating toward zero.
module kmc_div
    import kmc_pkg::*;
#(
    parameter int SUM_W = 22,
    parameter int CNT_W = 7
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int SW = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [SW-1:0]    step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CNT_W:0]   trial, diff;
    logic             fits;
    logic [SUM_W-1:0] mag, quo_neg;

    assign mag     = dividend[SUM_W-1] ? (~dividend) + 1'b1 : dividend;
    assign quo_neg = (~quo_reg) + 1'b1;
    assign trial   = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = trial >= {1'b0, dvs_reg};
    assign diff    = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = mag;
            step_next = SW'(SUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? signed'(quo_neg) : signed'(quo_reg);

endmodule

FILE: design/kmc_dp.sv
// Datapath: point and label memories, centres, distance unit, sums, dividers, output word.
module kmc_dp
    import kmc_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int JW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    parameter int PW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cmd_t          cmd,
    input  logic [JW-1:0] pt_idx,
    input  logic [PW-1:0] cl_idx,
    input  point_t        s_data,
    output status_t       status,
    output logic          m_valid,
    input  logic          m_ready,
    output result_t       m_data
);

    localparam int SUM_W = COORD_BITS + JW;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic signed [COORD_BITS-1:0] px_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] py_mem [MAX_POINTS];
    logic [PW-1:0]                lbl_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg;
    logic [PW-1:0]                lbl_reg;

    logic signed [COORD_BITS-1:0] mean_x_reg [MAX_CLUSTERS];
    logic signed [COORD_BITS-1:0] mean_y_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]      sum_x_reg [MAX_CLUSTERS];
    logic signed [SUM_W-1:0]      sum_y_reg [MAX_CLUSTERS];
    logic [CNT_W-1:0]             cnt_reg [MAX_CLUSTERS];

    logic [DIST_W-1:0]            sqx_reg, sqy_reg, best_reg, far_reg;
    logic [PW-1:0]                pd_reg, best_idx_reg;
    logic signed [COORD_BITS-1:0] far_x_reg, far_y_reg;

    logic                         m_valid_reg;
    result_t                      out_reg;

    logic signed [COORD_BITS-1:0] mx, my;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS:0]          ax, ay;
    logic [DIST_W-1:0]            prod_x, prod_y, dist_sum;
    logic [PW-1:0]                sum_sel;
    logic signed [SUM_W-1:0]      qx, qy;
    logic                         done_x, done_y;
    logic signed [COORD_BITS-1:0] qx_c, qy_c;

    assign mx       = mean_x_reg[cl_idx];
    assign my       = mean_y_reg[cl_idx];
    assign dx       = {mx[COORD_BITS-1], mx} - {pt_x_reg[COORD_BITS-1], pt_x_reg};
    assign dy       = {my[COORD_BITS-1], my} - {pt_y_reg[COORD_BITS-1], pt_y_reg};
    assign ax       = dx[COORD_BITS] ? -dx : dx;
    assign ay       = dy[COORD_BITS] ? -dy : dy;
    assign prod_x   = ax * ax;
    assign prod_y   = ay * ay;
    assign dist_sum = sqx_reg + sqy_reg;
    assign sum_sel  = cmd.sum_acc ? best_idx_reg : cl_idx;
    assign qx_c     = qx[COORD_BITS-1:0];
    assign qy_c     = qy[COORD_BITS-1:0];

    kmc_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_x_reg[sum_sel]),
        .divisor  (cnt_reg[sum_sel]),
        .done     (done_x),
        .quotient (qx)
    );

    kmc_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_y_reg[sum_sel]),
        .divisor  (cnt_reg[sum_sel]),
        .done     (done_y),
        .quotient (qy)
    );

    assign status.div_done  = done_x & done_y;
    assign status.changed   = (cnt_reg[sum_sel] != '0) &&
                              ((qx_c != mx) || (qy_c != my));
    assign status.lbl_match = lbl_reg == cl_idx;
    assign status.out_free  = !m_valid_reg || m_ready;

    // point and label memories, one shared read address
    always_ff @(posedge aclk) begin
        if (cmd.pt_wr) begin
            px_mem[pt_idx] <= s_data.point_x;
            py_mem[pt_idx] <= s_data.point_y;
        end
        if (cmd.lbl_wr) begin
            lbl_mem[pt_idx] <= best_idx_reg;
        end
        pt_x_reg <= px_mem[pt_idx];
        pt_y_reg <= py_mem[pt_idx];
        lbl_reg  <= lbl_mem[pt_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.dist_en) begin
            sqx_reg <= prod_x;
            sqy_reg <= prod_y;
            pd_reg  <= cl_idx;
        end
        if (cmd.cmp && (cmd.cmp_first || dist_sum < best_reg)) begin
            best_reg     <= dist_sum;
            best_idx_reg <= pd_reg;
        end
        if (cmd.far_upd && (cmd.far_first || best_reg > far_reg)) begin
            far_reg   <= best_reg;
            far_x_reg <= pt_x_reg;
            far_y_reg <= pt_y_reg;
        end
        if (cmd.mean0) begin
            mean_x_reg[0] <= pt_x_reg;
            mean_y_reg[0] <= pt_y_reg;
        end
        if (cmd.mean_far) begin
            mean_x_reg[cl_idx] <= far_x_reg;
            mean_y_reg[cl_idx] <= far_y_reg;
        end
        if (cmd.mean_upd && status.changed) begin
            mean_x_reg[cl_idx] <= qx_c;
            mean_y_reg[cl_idx] <= qy_c;
        end
        if (cmd.sum_clr) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                sum_x_reg[c] <= '0;
                sum_y_reg[c] <= '0;
                cnt_reg[c]   <= '0;
            end
        end else if (cmd.sum_acc) begin
            sum_x_reg[sum_sel] <= sum_x_reg[sum_sel] + SUM_W'(pt_x_reg);
            sum_y_reg[sum_sel] <= sum_y_reg[sum_sel] + SUM_W'(pt_y_reg);
            cnt_reg[sum_sel]   <= cnt_reg[sum_sel] + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.cluster_index <= 3'(cl_idx);
            out_reg.point_index   <= 6'(pt_idx);
            out_reg.centre_x      <= mx;
            out_reg.centre_y      <= my;
            out_reg.last_result   <= cmd.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: design/kmc_ctrl.sv
// Controller: configuration registers, loop counters and the sequencing state machine.
module kmc_ctrl
    import kmc_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int JW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    parameter int PW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  final_point,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  status_t               status,
    output cmd_t                  cmd,
    output logic [JW-1:0]         pt_idx,
    output logic [PW-1:0]         cl_idx
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_CLUSTERS + 1);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       load_reg, load_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       r_reg, r_next;
    logic [JW-1:0]       j_reg, j_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [PW-1:0]       i_reg, i_next;
    logic [LIMIT_W-1:0]  it_reg, it_next;
    logic                change_reg, change_next;
    logic [CCOUNT_W-1:0] cc_reg;
    logic [LIMIT_W-1:0]  lim_reg;

    logic [KW-1:0]       k_eff, near_lim;
    logic                j_more, p_more, k_more, i_more;

    always_comb begin
        if (cc_reg == '0) begin
            k_eff = KW'(1);
        end else if (32'(cc_reg) > MAX_CLUSTERS) begin
            k_eff = KW'(MAX_CLUSTERS);
        end else begin
            k_eff = KW'(cc_reg);
        end
    end

    assign near_lim = (phase_reg == PH_FP) ? KW'(i_reg) : k_eff;
    assign j_more   = (CW'(j_reg) + 1'b1) < n_reg;
    assign p_more   = (KW'(p_reg) + 1'b1) < near_lim;
    assign k_more   = (KW'(p_reg) + 1'b1) < k_eff;
    assign i_more   = (KW'(i_reg) + 1'b1) < k_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg  <= CLUSTER_COUNT_RST;
            lim_reg <= ITER_LIMIT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_CLUSTER_COUNT) begin
                cc_reg <= cfg_data[CCOUNT_W-1:0];
            end else if (cfg_index == CFG_ITER_LIMIT) begin
                lim_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            phase_reg  <= PH_FP;
            load_reg   <= '0;
            n_reg      <= '0;
            r_reg      <= '0;
            j_reg      <= '0;
            p_reg      <= '0;
            i_reg      <= '0;
            it_reg     <= '0;
            change_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            load_reg   <= load_next;
            n_reg      <= n_next;
            r_reg      <= r_next;
            j_reg      <= j_next;
            p_reg      <= p_next;
            i_reg      <= i_next;
            it_reg     <= it_next;
            change_reg <= change_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        load_next   = load_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        i_next      = i_reg;
        it_next     = it_reg;
        change_next = change_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        pt_idx      = j_reg;
        cl_idx      = p_reg;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                pt_idx  = load_reg[JW-1:0];
                if (s_valid) begin
                    if (load_reg < CW'(MAX_POINTS)) begin
                        cmd.pt_wr = 1'b1;
                        load_next = load_reg + 1'b1;
                    end
                    if (final_point) begin
                        n_next      = (load_reg < CW'(MAX_POINTS)) ? load_reg + 1'b1
                                                                   : load_reg;
                        j_next      = '0;
                        it_next     = '0;
                        change_next = 1'b1;
                        state_next  = ST_INIT0;
                    end
                end
            end
            ST_INIT0: begin
                state_next = ST_INIT1;
            end
            ST_INIT1: begin
                cmd.mean0 = 1'b1;
                if (k_eff == KW'(1)) begin
                    state_next = ST_IT_START;
                end else begin
                    i_next     = PW'(1);
                    j_next     = '0;
                    phase_next = PH_FP;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                p_next     = '0;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                cmd.dist_en = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp       = 1'b1;
                cmd.cmp_first = p_reg == '0;
                if (p_more) begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_DIST;
                end else begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                unique case (phase_reg)
                    PH_FP: begin
                        cmd.far_upd   = 1'b1;
                        cmd.far_first = j_reg == '0;
                    end
                    PH_LLOYD: cmd.sum_acc = 1'b1;
                    PH_LABEL: cmd.lbl_wr  = 1'b1;
                    default: ;
                endcase
                if (j_more) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    j_next = '0;
                    p_next = '0;
                    r_next = '0;
                    unique case (phase_reg)
                        PH_FP:    state_next = ST_FP_SET;
                        PH_LLOYD: state_next = ST_DIV_START;
                        PH_LABEL: state_next = ST_OUT_FETCH;
                        default:  state_next = ST_LOAD;
                    endcase
                end
            end
            ST_FP_SET: begin
                cl_idx       = i_reg;
                cmd.mean_far = 1'b1;
                if (i_more) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_IT_START;
                end
            end
            ST_IT_START: begin
                j_next = '0;
                if ((it_reg < lim_reg) && change_reg) begin
                    cmd.sum_clr = 1'b1;
                    change_next = 1'b0;
                    it_next     = it_reg + 1'b1;
                    phase_next  = PH_LLOYD;
                end else begin
                    phase_next = PH_LABEL;
                end
                state_next = ST_FETCH;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.mean_upd = 1'b1;
                    if (status.changed) begin
                        change_next = 1'b1;
                    end
                    if (k_more) begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_IT_START;
                    end
                end
            end
            ST_OUT_FETCH: begin
                state_next = ST_OUT_CHK;
            end
            ST_OUT_CHK: begin
                // a matching point waits here until the output word frees up
                if (!status.lbl_match || status.out_free) begin
                    if (status.lbl_match) begin
                        cmd.emit = 1'b1;
                        cmd.last = (r_reg + 1'b1) == n_reg;
                        r_next   = r_reg + 1'b1;
                    end
                    if (j_more) begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_OUT_FETCH;
                    end else if (k_more) begin
                        j_next     = '0;
                        p_next     = p_reg + 1'b1;
                        state_next = ST_OUT_FETCH;
                    end else begin
                        load_next  = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

endmodule

FILE: design/kmeans_2d_clustering.sv
// Points are taken one word per cycle into the point memory until final_point.
// Then setup (ST_INIT0, ST_INIT1); farthest-point centres c (1..k-1) are picked; each
// refinement pass sums points per nearest cluster, then divides (serial dividers).
// Labelling follows; the output scan walks clusters and points, stalled by the receiver;
// each word needs ST_OUT_FETCH and ST_OUT_CHK. No points are taken while a set is processed.
// Reset is synchronous, active low: counters and output valid clear, config takes defaults.
module kmeans_2d_clustering
    import kmc_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  point_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int JW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    cmd_t          cmd;
    status_t       status;
    logic [JW-1:0] pt_idx;
    logic [PW-1:0] cl_idx;

    assign cfg_ready = 1'b1;

    kmc_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .JW           (JW),
        .PW           (PW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .final_point (s_data.final_point),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .cmd         (cmd),
        .pt_idx      (pt_idx),
        .cl_idx      (cl_idx)
    );

    kmc_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .JW           (JW),
        .PW           (PW)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .pt_idx  (pt_idx),
        .cl_idx  (cl_idx),
        .s_data  (s_data),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("word emitted over a pending result");
    a_wr_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pt_wr |-> (s_valid && s_ready))
        else $error("point written without an accepted word");
    a_div_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !status.div_done)
        else $error("divider done right after start");
    a_upd_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mean_upd |-> status.div_done)
        else $error("centre updated before division finished");
`endif

endmodule

FILE: dv/tb_kmeans_2d_clustering.sv
// Self-checking testbench of the 2-D k-means clustering block: random point sets, config sweep.
module tb_kmeans_2d_clustering
    import kmc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS      = 64;
    localparam int NCLU      = 8;
    localparam int CYC_LIMIT = 40000000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    point_t                s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    result_t               m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kmeans_2d_clustering i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow of the block
    logic [CCOUNT_W-1:0] sh_clusters = CLUSTER_COUNT_RST;
    logic [LIMIT_W-1:0]  sh_limit = ITER_LIMIT_RST;
    longint              pt_x [NPTS];
    longint              pt_y [NPTS];
    int                  pts_held = 0;

    point_t  pending_points [$];
    result_t expected_labels [$];
    int      fail_cnt = 0;
    int      stall_mode = 0;
    int      cycle_cnt = 0;

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic int closest_centre(int j, int kc, const ref longint cx[NCLU],
                                          const ref longint cy[NCLU], output longint best_d);
        int     best;
        longint d;
        best = 0;
        best_d = sq_dist(cx[0], cy[0], pt_x[j], pt_y[j]);
        for (int p = 1; p < kc; p++) begin
            d = sq_dist(cx[p], cy[p], pt_x[j], pt_y[j]);
            if (d < best_d) begin
                best_d = d;
                best = p;
            end
        end
        return best;
    endfunction

    function automatic void cluster_point(point_t pt);
        int      n, kc, pick, lbl, cnt;
        longint  far_d, d, nx, ny;
        longint  cx [NCLU];
        longint  cy [NCLU];
        longint  acc_x [NCLU];
        longint  acc_y [NCLU];
        int      members [NCLU];
        int      labels [NPTS];
        bit      moved;
        result_t r;
        if (pts_held < NPTS) begin
            pt_x[pts_held] = longint'(pt.point_x);
            pt_y[pts_held] = longint'(pt.point_y);
            pts_held++;
        end
        if (!pt.final_point) return;
        n = pts_held;
        kc = int'(sh_clusters);
        if (kc < 1) kc = 1;
        if (kc > NCLU) kc = NCLU;
        for (int p = 0; p < NCLU; p++) begin
            cx[p] = 0;
            cy[p] = 0;
        end
        cx[0] = pt_x[0];
        cy[0] = pt_y[0];
        for (int i = 1; i < kc; i++) begin
            pick = 0;
            far_d = 0;
            for (int j = 0; j < n; j++) begin
                void'(closest_centre(j, i, cx, cy, d));
                if (j == 0 || d > far_d) begin
                    far_d = d;
                    pick = j;
                end
            end
            cx[i] = pt_x[pick];
            cy[i] = pt_y[pick];
        end
        moved = 1'b1;
        for (int it = 0; it < int'(sh_limit) && moved; it++) begin
            moved = 1'b0;
            for (int p = 0; p < kc; p++) begin
                acc_x[p] = 0;
                acc_y[p] = 0;
                members[p] = 0;
            end
            for (int j = 0; j < n; j++) begin
                lbl = closest_centre(j, kc, cx, cy, d);
                acc_x[lbl] += pt_x[j];
                acc_y[lbl] += pt_y[j];
                members[lbl]++;
            end
            for (int p = 0; p < kc; p++) begin
                if (members[p] == 0) continue;  // empty cluster keeps its centre
                nx = acc_x[p] / members[p];
                ny = acc_y[p] / members[p];
                if (nx != cx[p] || ny != cy[p]) begin
                    moved = 1'b1;
                    cx[p] = nx;
                    cy[p] = ny;
                end
            end
        end
        for (int j = 0; j < n; j++) labels[j] = closest_centre(j, kc, cx, cy, d);
        cnt = 0;
        for (int p = 0; p < kc; p++) begin
            for (int j = 0; j < n; j++) begin
                if (labels[j] != p) continue;
                r.cluster_index = 3'(p);
                r.point_index   = 6'(j);
                r.centre_x      = COORD_BITS'(cx[p]);
                r.centre_y      = COORD_BITS'(cy[p]);
                r.last_result   = (cnt + 1 == n);
                expected_labels.insert(expected_labels.size(), r);
                cnt++;
            end
        end
        pts_held = 0;
    endfunction

    // point driver: bursts with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) cluster_point(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_points.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_labels.size() == 0) begin
                    $error("unexpected result word: cluster %0d point %0d",
                           m_data.cluster_index, m_data.point_index);
                    fail_cnt++;
                end else begin
                    result_t e;
                    e = expected_labels.pop_front();
                    if (m_data.cluster_index !== e.cluster_index) begin
                        $error("cluster_index exp %0d got %0d", e.cluster_index,
                               m_data.cluster_index);
                        fail_cnt++;
                    end
                    if (m_data.point_index !== e.point_index) begin
                        $error("point_index exp %0d got %0d", e.point_index, m_data.point_index);
                        fail_cnt++;
                    end
                    if (m_data.centre_x !== e.centre_x) begin
                        $error("centre_x exp %0d got %0d", e.centre_x, m_data.centre_x);
                        fail_cnt++;
                    end
                    if (m_data.centre_y !== e.centre_y) begin
                        $error("centre_y exp %0d got %0d", e.centre_y, m_data.centre_y);
                        fail_cnt++;
                    end
                    if (m_data.last_result !== e.last_result) begin
                        $error("last_result exp %0d got %0d", e.last_result,
                               m_data.last_result);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 20);
                    end
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYC_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CLUSTER_COUNT) sh_clusters = val[CCOUNT_W-1:0];
        else if (idx == CFG_ITER_LIMIT) sh_limit = val;
    endtask

    task automatic add_point(int x, int y, bit last);
        point_t p;
        p.point_x = COORD_BITS'(x);
        p.point_y = COORD_BITS'(y);
        p.final_point = last;
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic drain;
        while (pending_points.size() > 0 || s_valid || expected_labels.size() > 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // n points, either spread over the whole plane or around a few blobs
    task automatic add_set(int n);
        int blobs, bx [4], by [4], spread, b;
        blobs = $urandom_range(0, 4);
        spread = 1 << $urandom_range(2, 12);
        for (int i = 0; i < 4; i++) begin
            bx[i] = $urandom_range(0, 65535) - 32768;
            by[i] = $urandom_range(0, 65535) - 32768;
        end
        for (int i = 0; i < n; i++) begin
            if (blobs == 0) begin
                add_point($urandom_range(0, 65535), $urandom_range(0, 65535), i == n - 1);
            end else begin
                b = $urandom_range(0, blobs - 1);
                add_point(bx[b] + $urandom_range(0, spread) - spread / 2,
                          by[b] + $urandom_range(0, spread) - spread / 2, i == n - 1);
            end
        end
    endtask

    initial begin
        int items;
        int sz;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: extremes, single point, duplicates
        add_point(-32768, -32768, 0);
        add_point(32767, 32767, 0);
        add_point(0, 0, 0);
        add_point(-1, 1, 1);
        add_point(32767, -32768, 1);
        add_point(5, 5, 0);
        add_point(5, 5, 0);
        add_point(5, 5, 1);
        drain();

        // more clusters than points, no refinement
        stall_mode = 1;
        write_reg(CFG_CLUSTER_COUNT, 8'd8);
        write_reg(CFG_ITER_LIMIT, 8'd0);
        add_point(100, -200, 0);
        add_point(-300, 400, 0);
        add_point(100, -200, 1);
        drain();

        // zero cluster count, high data bits set
        stall_mode = 2;
        write_reg(CFG_CLUSTER_COUNT, 8'hF0);
        write_reg(CFG_ITER_LIMIT, 8'd255);
        add_point(-32768, 32767, 0);
        add_point(32767, -32768, 0);
        add_point(1, -1, 0);
        add_point(-2, 2, 1);
        drain();

        // oversized count saturates
        write_reg(CFG_CLUSTER_COUNT, 8'd15);
        write_reg(CFG_ITER_LIMIT, 8'd1);
        add_set(6);
        drain();

        // full memory plus dropped points
        stall_mode = 0;
        write_reg(CFG_CLUSTER_COUNT, 8'd8);
        write_reg(CFG_ITER_LIMIT, 8'd4);
        add_set(67);
        drain();

        items = 0;
        while (items < 160) begin
            stall_mode = $urandom_range(0, 3);
            write_reg(CFG_CLUSTER_COUNT, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_ITER_LIMIT, 8'd255);
                1: write_reg(CFG_ITER_LIMIT, 8'($urandom_range(0, 3)));
                default: write_reg(CFG_ITER_LIMIT, 8'($urandom_range(0, 255)));
            endcase
            repeat ($urandom_range(2, 4)) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
                add_set(sz);
                items += sz;
            end
            drain();
        end

        drain();
        repeat (200) @(negedge aclk);
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: kmeans_2d_clustering.f
design/kmc_pkg.sv
design/kmc_div.sv
design/kmc_dp.sv
design/kmc_ctrl.sv
design/kmeans_2d_clustering.sv
dv/tb_kmeans_2d_clustering.sv
